/* rtl/core/ecsr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecsr_pkg
// Shared sizes, codes and record types of the edge-list to CSR builder.
// ----------------------------------------------------------------------------
package ecsr_pkg;

  // Capacity of the node tables and of the edge and slot stores
  localparam int unsigned MAX_NODES = 1024;
  localparam int unsigned MAX_EDGES = 4096;

  localparam int unsigned NODE_W  = $clog2(MAX_NODES);
  localparam int unsigned EADDR_W = $clog2(MAX_EDGES);
  localparam int unsigned CNT_W   = $clog2(MAX_EDGES + 1);
  localparam int unsigned NUSE_W  = $clog2(MAX_NODES + 1);

  // Field widths of the item formats
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SRC_W    = 10;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned ROW_W    = 13;
  localparam int unsigned NCFG_W   = 11;

  // Configuration port
  localparam int unsigned APB_AW         = 3;
  localparam int unsigned APB_DW         = 32;
  localparam int unsigned REG_IDX_W      = APB_AW - 2;
  localparam int unsigned REG_NODE_COUNT = 0;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD  = 2'd0,
    REQ_BUILD = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_FULL        = 2'd1,
    STAT_NODE_RANGE  = 2'd2,
    STAT_INDEX_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [SRC_W-1:0]    src;
    logic [SRC_W-1:0]    dst;
    logic [WEIGHT_W-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic [CNT_W-1:0] offset;
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum;
  } node_t;

  typedef struct packed {
    logic [SRC_W-1:0]    dest;
    logic [WEIGHT_W-1:0] weight;
  } csr_t;

  typedef struct packed {
    status_e             status;
    logic [ROW_W-1:0]    row_start;
    logic [ROW_W-1:0]    row_end;
    logic [SUM_W-1:0]    out_total;
    logic [SRC_W-1:0]    slot_dest;
    logic [WEIGHT_W-1:0] slot_weight;
    logic [ROW_W-1:0]    edges_held;
  } res_t;

endpackage

/* rtl/core/ecsr_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecsr_cfg
// APB register file: holds node_count and presents the node count in use,
// clamped to the table capacity.
// ----------------------------------------------------------------------------
module ecsr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ecsr_pkg::APB_AW-1:0]   paddr,
  input  logic [ecsr_pkg::APB_DW-1:0]   pwdata,
  output logic [ecsr_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output logic [ecsr_pkg::NUSE_W-1:0]   n_use_o
);
  import ecsr_pkg::*;

  logic [NCFG_W-1:0]    node_count_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 hit_node_count;

  assign pready         = 1'b1;
  assign reg_idx        = paddr[APB_AW-1:2];
  assign hit_node_count = (reg_idx == REG_IDX_W'(REG_NODE_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NCFG_W'(1);
    end else if (psel && penable && pwrite && pready && hit_node_count) begin
      node_count_q <= pwdata[NCFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit_node_count) begin
      prdata = APB_DW'(node_count_q);
    end
  end

  // Clamp to the table capacity
  always_comb begin
    if (32'(node_count_q) > 32'(MAX_NODES)) begin
      n_use_o = NUSE_W'(MAX_NODES);
    end else begin
      n_use_o = NUSE_W'(node_count_q);
    end
  end

endmodule

/* rtl/core/edge_list_to_csr_builder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_list_to_csr_builder_top
// Loads weighted edges, builds a compressed-sparse-row image on request and
// reads back row bounds, outgoing totals and slot contents.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Content
//  s_axis    in         tvalid & tready            request item
//  m_axis    out        tvalid & tready            result item, one per request
//  apb       in/out     psel & penable & pwrite    node_count register
//
//  Read goes through the node table and slot store read ports. Clear zeroes
//  one node-table entry per cycle. Build zeroes the node table, counts
//  out-degrees, forms row offsets and scatters edges, skipping out-of-range
//  ones; each placed edge reads, then writes, its node-table entry.
//  After reset the node table is zeroed; no item is taken until that is done.
//  A waiting result holds the request side until m_axis takes it.
// ----------------------------------------------------------------------------
module edge_list_to_csr_builder_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request: tdata = src_node, dst_node, edge_weight, read_index
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [63:0]                  s_axis_tdata,
  // request: tuser = req_type
  input  logic [ecsr_pkg::REQ_W-1:0]   s_axis_tuser,
  // result: tdata = row_start, row_end, out_total, slot_dest, slot_weight,
  //         edges_held, zero fill
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [135:0]                 m_axis_tdata,
  // result: tuser = status
  output logic [ecsr_pkg::STATUS_W-1:0] m_axis_tuser,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ecsr_pkg::APB_AW-1:0]  paddr,
  input  logic [ecsr_pkg::APB_DW-1:0]  pwdata,
  output logic [ecsr_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import ecsr_pkg::*;

  localparam int unsigned OUT_USED_W = 3 * ROW_W + SUM_W + SRC_W + WEIGHT_W;
  localparam int unsigned OUT_PAD_W  = 136 - OUT_USED_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_RD,
    S_P1_E, S_P1_N, S_P1_W,
    S_P2_R, S_P2_W,
    S_P3_E, S_P3_N, S_P3_W
  } state_e;

  typedef enum logic [1:0] {
    SW_INIT, SW_CLEAR, SW_BUILD
  } sweep_e;

  // Configuration
  logic [NUSE_W-1:0] n_use;

  ecsr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .n_use_o (n_use)
  );

  // Request fields
  req_e                req;
  logic [SRC_W-1:0]    in_src;
  logic [SRC_W-1:0]    in_dst;
  logic [WEIGHT_W-1:0] in_weight;
  logic [IDX_W-1:0]    in_idx;

  assign req       = req_e'(s_axis_tuser);
  assign in_src    = s_axis_tdata[9:0];
  assign in_dst    = s_axis_tdata[19:10];
  assign in_weight = s_axis_tdata[51:20];
  assign in_idx    = s_axis_tdata[63:52];

  // Control state
  state_e            state_q;
  sweep_e            sweep_q;
  logic [NODE_W-1:0] ptr_q;
  logic [CNT_W-1:0]  e_q;
  logic [CNT_W-1:0]  acc_q;
  logic [CNT_W-1:0]  edges_q;
  logic              node_ok_q;
  logic              slot_ok_q;
  logic              m_valid_q;
  res_t              res_q;

  // Memories
  edge_t edge_mem [MAX_EDGES];
  node_t node_mem [MAX_NODES];
  csr_t  csr_mem  [MAX_EDGES];

  edge_t edge_rd_q;
  node_t node_rd_q;
  csr_t  csr_rd_q;

  logic               edge_we, edge_re;
  logic [EADDR_W-1:0] edge_waddr;
  edge_t              edge_wdata;
  logic               node_we, node_re;
  logic [NODE_W-1:0]  node_waddr, node_raddr;
  node_t              node_wdata;
  logic               csr_we, csr_re;
  logic [EADDR_W-1:0] csr_waddr, csr_raddr;
  csr_t               csr_wdata;

  // Derived control
  logic              in_acc;
  logic              store_full;
  logic              load_bad_node;
  logic              load_ok;
  logic              edges_done;
  logic              edge_ok;
  logic              ptr_last;
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_sat;
  logic [CNT_W-1:0]  slot_pos;

  assign s_axis_tready = (state_q == S_IDLE) && (!m_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign store_full    = (edges_q == CNT_W'(MAX_EDGES));
  assign load_bad_node = (32'(in_src) >= 32'(n_use)) || (32'(in_dst) >= 32'(n_use));
  assign load_ok       = in_acc && (req == REQ_LOAD) && !store_full && !load_bad_node;

  assign edges_done = (e_q == edges_q);
  assign edge_ok    = (32'(edge_rd_q.src) < 32'(n_use)) && (32'(edge_rd_q.dst) < 32'(n_use));
  assign ptr_last   = (ptr_q == NODE_W'(MAX_NODES - 1));

  // Saturate the outgoing total at its top value
  assign sum_ext  = {1'b0, node_rd_q.sum} + (SUM_W + 1)'(edge_rd_q.weight);
  assign sum_sat  = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
  assign slot_pos = node_rd_q.offset + node_rd_q.count;

  // Memory port control
  always_comb begin
    edge_we    = load_ok;
    edge_waddr = edges_q[EADDR_W-1:0];
    edge_wdata = '{src: in_src, dst: in_dst, weight: in_weight};
    edge_re    = ((state_q == S_P1_E) || (state_q == S_P3_E)) && !edges_done;

    node_we    = 1'b0;
    node_waddr = ptr_q;
    node_wdata = '0;
    node_re    = 1'b0;
    node_raddr = ptr_q;

    csr_we     = 1'b0;
    csr_waddr  = slot_pos[EADDR_W-1:0];
    csr_wdata  = '{dest: edge_rd_q.dst, weight: edge_rd_q.weight};
    csr_re     = 1'b0;
    csr_raddr  = in_idx[EADDR_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_acc && (req == REQ_READ)) begin
          node_re    = 1'b1;
          node_raddr = in_idx[NODE_W-1:0];
          csr_re     = 1'b1;
        end
      end
      S_CLR: begin
        node_we = 1'b1;
      end
      S_P1_N, S_P3_N: begin
        node_re    = edge_ok;
        node_raddr = edge_rd_q.src[NODE_W-1:0];
      end
      S_P1_W: begin
        node_we          = 1'b1;
        node_waddr       = edge_rd_q.src[NODE_W-1:0];
        node_wdata       = node_rd_q;
        node_wdata.count = node_rd_q.count + CNT_W'(1);
      end
      S_P2_R: begin
        node_re = 1'b1;
      end
      S_P2_W: begin
        // Row offset from the running sum; drop cursor and total for pass 3
        node_we    = 1'b1;
        node_wdata = '{offset: acc_q, count: '0, sum: '0};
      end
      S_P3_W: begin
        node_we    = 1'b1;
        node_waddr = edge_rd_q.src[NODE_W-1:0];
        node_wdata = '{offset: node_rd_q.offset,
                       count:  node_rd_q.count + CNT_W'(1),
                       sum:    sum_sat};
        csr_we     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    if (edge_re) begin
      edge_rd_q <= edge_mem[e_q[EADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (node_re) begin
      node_rd_q <= node_mem[node_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (csr_we) begin
      csr_mem[csr_waddr] <= csr_wdata;
    end
    if (csr_re) begin
      csr_rd_q <= csr_mem[csr_raddr];
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      sweep_q   <= SW_INIT;
      ptr_q     <= '0;
      e_q       <= '0;
      acc_q     <= '0;
      edges_q   <= '0;
      node_ok_q <= 1'b0;
      slot_ok_q <= 1'b0;
      m_valid_q <= 1'b0;
      res_q     <= '0;
    end else begin
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (req)
              REQ_LOAD: begin
                m_valid_q        <= 1'b1;
                res_q            <= '0;
                res_q.edges_held <= ROW_W'(edges_q + CNT_W'(load_ok));
                if (store_full) begin
                  res_q.status <= STAT_FULL;
                end else if (load_bad_node) begin
                  res_q.status <= STAT_NODE_RANGE;
                end else begin
                  res_q.status <= STAT_OK;
                end
                edges_q <= edges_q + CNT_W'(load_ok);
              end
              REQ_BUILD: begin
                state_q <= S_CLR;
                sweep_q <= SW_BUILD;
                ptr_q   <= '0;
              end
              REQ_READ: begin
                state_q   <= S_RD;
                node_ok_q <= (32'(in_idx) < 32'(n_use));
                slot_ok_q <= (32'(in_idx) < 32'(MAX_EDGES));
              end
              REQ_CLEAR: begin
                state_q <= S_CLR;
                sweep_q <= SW_CLEAR;
                ptr_q   <= '0;
                edges_q <= '0;
              end
              default: begin
              end
            endcase
          end
        end

        S_CLR: begin
          ptr_q <= ptr_q + NODE_W'(1);
          if (ptr_last) begin
            case (sweep_q)
              SW_BUILD: begin
                state_q <= S_P1_E;
                e_q     <= '0;
              end
              SW_CLEAR: begin
                state_q          <= S_IDLE;
                m_valid_q        <= 1'b1;
                res_q            <= '0;
                res_q.status     <= STAT_OK;
                res_q.edges_held <= ROW_W'(edges_q);
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end

        S_RD: begin
          state_q          <= S_IDLE;
          m_valid_q        <= 1'b1;
          res_q            <= '0;
          res_q.edges_held <= ROW_W'(edges_q);
          if (node_ok_q) begin
            res_q.status    <= STAT_OK;
            res_q.row_start <= ROW_W'(node_rd_q.offset);
            res_q.row_end   <= ROW_W'(slot_pos);
            res_q.out_total <= node_rd_q.sum;
          end else begin
            res_q.status <= STAT_INDEX_RANGE;
          end
          if (slot_ok_q) begin
            res_q.slot_dest   <= csr_rd_q.dest;
            res_q.slot_weight <= csr_rd_q.weight;
          end
        end

        // Pass 1: count out-degree of each source
        S_P1_E: begin
          if (edges_done) begin
            state_q <= S_P2_R;
            ptr_q   <= '0;
            acc_q   <= '0;
          end else begin
            state_q <= S_P1_N;
          end
        end
        S_P1_N: begin
          if (edge_ok) begin
            state_q <= S_P1_W;
          end else begin
            e_q     <= e_q + CNT_W'(1);
            state_q <= S_P1_E;
          end
        end
        S_P1_W: begin
          e_q     <= e_q + CNT_W'(1);
          state_q <= S_P1_E;
        end

        // Pass 2: prefix sum into row offsets
        S_P2_R: begin
          state_q <= S_P2_W;
        end
        S_P2_W: begin
          acc_q <= acc_q + node_rd_q.count;
          if (ptr_last) begin
            state_q <= S_P3_E;
            e_q     <= '0;
          end else begin
            ptr_q   <= ptr_q + NODE_W'(1);
            state_q <= S_P2_R;
          end
        end

        // Pass 3: scatter edges through the per-source cursor
        S_P3_E: begin
          if (edges_done) begin
            state_q          <= S_IDLE;
            m_valid_q        <= 1'b1;
            res_q            <= '0;
            res_q.status     <= STAT_OK;
            res_q.edges_held <= ROW_W'(edges_q);
          end else begin
            state_q <= S_P3_N;
          end
        end
        S_P3_N: begin
          if (edge_ok) begin
            state_q <= S_P3_W;
          end else begin
            e_q     <= e_q + CNT_W'(1);
            state_q <= S_P3_E;
          end
        end
        S_P3_W: begin
          e_q     <= e_q + CNT_W'(1);
          state_q <= S_P3_E;
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = res_q.status;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}},
                          res_q.edges_held,
                          res_q.slot_weight,
                          res_q.slot_dest,
                          res_q.out_total,
                          res_q.row_end,
                          res_q.row_start};

endmodule
